FILE: rtl/gad_pkg.sv
// shared constants, types and the arctangent table for the gradient angle difference block
package gad_pkg;

  // sample and angle formats
  localparam int PIXEL_BITS    = 16;
  localparam int FRACTION_BITS = 15;
  localparam int PORT_W        = 16;
  localparam int OUT_W         = 16;
  localparam int SAMPLE_W      = (PIXEL_BITS < PORT_W) ? PIXEL_BITS : PORT_W;
  localparam int DIFF_W        = SAMPLE_W + 1;

  // cordic datapath
  localparam int PRESCALE      = 28;
  localparam int TABLE_LEN     = 28;
  localparam int STEP_COUNT    = FRACTION_BITS + 3;
  localparam int CORDIC_STEPS  = (STEP_COUNT < TABLE_LEN) ? STEP_COUNT : TABLE_LEN;
  localparam int CORDIC_W      = DIFF_W + PRESCALE + 3;
  localparam int ANGLE_W       = 32;
  localparam int TURN_W        = FRACTION_BITS + 1;
  localparam int CORDIC_LAT    = CORDIC_STEPS + 1;

  // atan(2^-i) in half-turns, 31 fraction bits
  localparam logic [ANGLE_W-1:0] ATAN_TABLE [TABLE_LEN] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465,  32'd10679838,  32'd5340247,   32'd2670163,  32'd1335087,
    32'd667544,    32'd333772,    32'd166886,    32'd83443,    32'd41722,
    32'd20861,     32'd10430,     32'd5215,      32'd2608,     32'd1304,
    32'd652,       32'd326,       32'd163,       32'd81,       32'd41,
    32'd20,        32'd10,        32'd5
  };

  // per-pixel flags that ride alongside the cordic pipelines
  typedef struct packed {
    logic border;
    logic flat;
  } gad_side_t;

endpackage

FILE: rtl/gad_front.sv
// input stage: central differences and zero-gradient detection for both images
module gad_front import gad_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     en,
  input  logic                     in_valid,
  input  logic                     on_border,
  input  logic [PORT_W-1:0]        first_left,
  input  logic [PORT_W-1:0]        first_right,
  input  logic [PORT_W-1:0]        first_up,
  input  logic [PORT_W-1:0]        first_down,
  input  logic [PORT_W-1:0]        second_left,
  input  logic [PORT_W-1:0]        second_right,
  input  logic [PORT_W-1:0]        second_up,
  input  logic [PORT_W-1:0]        second_down,
  output logic                     valid,
  output gad_side_t                side,
  output logic signed [DIFF_W-1:0] dx0,
  output logic signed [DIFF_W-1:0] dy0,
  output logic signed [DIFF_W-1:0] dx1,
  output logic signed [DIFF_W-1:0] dy1
);

  logic signed [DIFF_W-1:0] dx0_next, dy0_next, dx1_next, dy1_next;

  assign dx0_next = $signed({1'b0, first_right[SAMPLE_W-1:0]})
                  - $signed({1'b0, first_left[SAMPLE_W-1:0]});
  assign dy0_next = $signed({1'b0, first_down[SAMPLE_W-1:0]})
                  - $signed({1'b0, first_up[SAMPLE_W-1:0]});
  assign dx1_next = $signed({1'b0, second_right[SAMPLE_W-1:0]})
                  - $signed({1'b0, second_left[SAMPLE_W-1:0]});
  assign dy1_next = $signed({1'b0, second_down[SAMPLE_W-1:0]})
                  - $signed({1'b0, second_up[SAMPLE_W-1:0]});

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (en) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side.border <= on_border;
      side.flat   <= ((dx0_next == '0) && (dy0_next == '0))
                  || ((dx1_next == '0) && (dy1_next == '0));
      dx0 <= dx0_next;
      dy0 <= dy0_next;
      dx1 <= dx1_next;
      dy1 <= dy1_next;
    end
  end

endmodule

FILE: rtl/gad_cordic.sv
// pipelined vectoring cordic, one micro-rotation per stage, angle in half-turns
module gad_cordic import gad_pkg::*; (
  input  logic                     clk,
  input  logic                     en,
  input  logic signed [DIFF_W-1:0] dx,
  input  logic signed [DIFF_W-1:0] dy,
  output logic [ANGLE_W-1:0]       angle
);

  localparam int EXT_W = CORDIC_W - DIFF_W - PRESCALE;

  logic signed [CORDIC_W-1:0] x_init, y_init;
  logic signed [CORDIC_W-1:0] xs [CORDIC_STEPS+1];
  logic signed [CORDIC_W-1:0] ys [CORDIC_STEPS+1];
  logic [ANGLE_W-1:0]         zs [CORDIC_STEPS+1];

  assign x_init = {{EXT_W{dx[DIFF_W-1]}}, dx, {PRESCALE{1'b0}}};
  assign y_init = {{EXT_W{dy[DIFF_W-1]}}, dy, {PRESCALE{1'b0}}};

  // left half-plane: rotate by a half-turn first
  always_ff @(posedge clk) begin
    if (en) begin
      if (x_init[CORDIC_W-1]) begin
        xs[0] <= -x_init;
        ys[0] <= -y_init;
        zs[0] <= ANGLE_W'(1) << (ANGLE_W - 1);
      end else begin
        xs[0] <= x_init;
        ys[0] <= y_init;
        zs[0] <= '0;
      end
    end
  end

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
    always_ff @(posedge clk) begin
      if (en) begin
        if (ys[i][CORDIC_W-1]) begin
          xs[i+1] <= xs[i] - (ys[i] >>> i);
          ys[i+1] <= ys[i] + (xs[i] >>> i);
          zs[i+1] <= zs[i] - ATAN_TABLE[i];
        end else begin
          xs[i+1] <= xs[i] + (ys[i] >>> i);
          ys[i+1] <= ys[i] - (xs[i] >>> i);
          zs[i+1] <= zs[i] + ATAN_TABLE[i];
        end
      end
    end
  end

  assign angle = zs[CORDIC_STEPS];

endmodule

FILE: rtl/gad_back.sv
// output stages: angle rounding, wrapped difference and result register
module gad_back import gad_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               valid_in,
  input  gad_side_t          side_in,
  input  logic [ANGLE_W-1:0] angle_a,
  input  logic [ANGLE_W-1:0] angle_b,
  output logic               out_valid,
  output logic               defined,
  output logic [OUT_W-1:0]   angle_difference
);

  localparam logic [ANGLE_W-1:0] HALF = ANGLE_W'(1) << (ANGLE_W - 2 - FRACTION_BITS);
  localparam logic [TURN_W-1:0]  ONE  = TURN_W'(1) << FRACTION_BITS;

  logic [ANGLE_W-1:0] sum_a, sum_b;
  logic [TURN_W-1:0]  diff_next, diff, wrapped;
  logic               valid_d;
  gad_side_t          side_d;

  // round to nearest, ties up, modulo one full turn
  assign sum_a     = angle_a + HALF;
  assign sum_b     = angle_b + HALF;
  assign diff_next = sum_a[ANGLE_W-1 -: TURN_W] - sum_b[ANGLE_W-1 -: TURN_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_d <= 1'b0;
    end else if (en) begin
      valid_d <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_d <= side_in;
      diff   <= diff_next;
    end
  end

  // fold into [0, one half-turn]
  assign wrapped = (diff > ONE) ? (~diff + 1'b1) : diff;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= valid_d;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      defined <= ~side_d.border;
      priority if (side_d.border) begin
        angle_difference <= '0;
      end else if (side_d.flat) begin
        angle_difference <= OUT_W'(ONE);
      end else begin
        angle_difference <= OUT_W'(wrapped);
      end
    end
  end

endmodule

FILE: rtl/gradient_angle_difference_top.sv
// top level of the gradient angle difference block
//
//   channel | handshake                 | payload
//   --------+---------------------------+-------------------------------------------
//   in      | in_valid / in_stall       | on_border, first_*, second_* (16 b each)
//   out     | out_valid / out_stall     | defined, angle_difference (q1.15)
//
// one request per cycle while the output is not held; stages: difference stage,
// 19 cordic stages per image, rounding/difference stage, output register
// the pipeline depth is set by the 18 micro-rotations of the cordic
// all stages advance together; a held result at the output freezes the
// whole pipeline and raises in_stall, nothing is lost or repeated
// synchronous reset clears only the valid bits; payload registers are not reset
module gradient_angle_difference_top import gad_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  // input channel
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              on_border,
  input  logic [PORT_W-1:0] first_left,
  input  logic [PORT_W-1:0] first_right,
  input  logic [PORT_W-1:0] first_up,
  input  logic [PORT_W-1:0] first_down,
  input  logic [PORT_W-1:0] second_left,
  input  logic [PORT_W-1:0] second_right,
  input  logic [PORT_W-1:0] second_up,
  input  logic [PORT_W-1:0] second_down,
  // output channel
  output logic              out_valid,
  input  logic              out_stall,
  output logic              defined,
  output logic [OUT_W-1:0]  angle_difference
);

  // pipeline advance: only a result that is shown and refused holds things up
  logic en;
  assign en       = ~(out_valid & out_stall);
  assign in_stall = ~en;

  // difference stage
  logic                     front_valid;
  gad_side_t                front_side;
  logic signed [DIFF_W-1:0] dx0, dy0, dx1, dy1;

  gad_front u_front (
    .clk          (clk),
    .rst          (rst),
    .en           (en),
    .in_valid     (in_valid),
    .on_border    (on_border),
    .first_left   (first_left),
    .first_right  (first_right),
    .first_up     (first_up),
    .first_down   (first_down),
    .second_left  (second_left),
    .second_right (second_right),
    .second_up    (second_up),
    .second_down  (second_down),
    .valid        (front_valid),
    .side         (front_side),
    .dx0          (dx0),
    .dy0          (dy0),
    .dx1          (dx1),
    .dy1          (dy1)
  );

  // one cordic per image, both run in lockstep
  logic [ANGLE_W-1:0] angle_a, angle_b;

  gad_cordic u_cordic_first (
    .clk   (clk),
    .en    (en),
    .dx    (dx0),
    .dy    (dy0),
    .angle (angle_a)
  );

  gad_cordic u_cordic_second (
    .clk   (clk),
    .en    (en),
    .dx    (dx1),
    .dy    (dy1),
    .angle (angle_b)
  );

  // valid bits and pixel flags travel beside the cordic stages
  logic      valid_line [CORDIC_LAT];
  gad_side_t side_line  [CORDIC_LAT];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CORDIC_LAT; i++) begin
        valid_line[i] <= 1'b0;
      end
    end else if (en) begin
      valid_line[0] <= front_valid;
      for (int i = 1; i < CORDIC_LAT; i++) begin
        valid_line[i] <= valid_line[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_line[0] <= front_side;
      for (int i = 1; i < CORDIC_LAT; i++) begin
        side_line[i] <= side_line[i-1];
      end
    end
  end

  // rounding, wrapped difference and the output register
  gad_back u_back (
    .clk              (clk),
    .rst              (rst),
    .en               (en),
    .valid_in         (valid_line[CORDIC_LAT-1]),
    .side_in          (side_line[CORDIC_LAT-1]),
    .angle_a          (angle_a),
    .angle_b          (angle_b),
    .out_valid        (out_valid),
    .defined          (defined),
    .angle_difference (angle_difference)
  );

endmodule

FILE: tb/gradient_angle_difference_monitor.sv
// watches both channels of the gradient angle difference block and checks every result
module gradient_angle_difference_monitor import gad_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              in_stall,
  input  logic              on_border,
  input  logic [PORT_W-1:0] first_left,
  input  logic [PORT_W-1:0] first_right,
  input  logic [PORT_W-1:0] first_up,
  input  logic [PORT_W-1:0] first_down,
  input  logic [PORT_W-1:0] second_left,
  input  logic [PORT_W-1:0] second_right,
  input  logic [PORT_W-1:0] second_up,
  input  logic [PORT_W-1:0] second_down,
  input  logic              out_valid,
  input  logic              out_stall,
  input  logic              defined,
  input  logic [OUT_W-1:0]  angle_difference,
  output int                failures,
  output int                outstanding
);

  typedef struct packed {
    logic             defined;
    logic [OUT_W-1:0] angle;
  } orientation_result_t;

  localparam int               FRAC       = 15;
  localparam int               ROTATIONS  = FRAC + 3;
  localparam int               GAIN_SHIFT = 28;
  localparam logic [OUT_W-1:0] FULL_SCALE = 16'd32768;

  // atan(2^-i) in half-turns, 31 fraction bits
  localparam logic [31:0] ARCTAN_HALF_TURNS [28] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465,  32'd10679838,  32'd5340247,   32'd2670163,  32'd1335087,
    32'd667544,    32'd333772,    32'd166886,    32'd83443,    32'd41722,
    32'd20861,     32'd10430,     32'd5215,      32'd2608,     32'd1304,
    32'd652,       32'd326,       32'd163,       32'd81,       32'd41,
    32'd20,        32'd10,        32'd5
  };

  orientation_result_t expected_differences[$];

  function automatic longint central_difference(input logic [PORT_W-1:0] lo,
                                                 input logic [PORT_W-1:0] hi);
    longint a;
    longint b;
    a = hi;
    b = lo;
    return a - b;
  endfunction

  // vectoring cordic, angle in half-turns modulo one full turn
  function automatic logic [OUT_W-1:0] gradient_heading(input longint dx, input longint dy);
    longint              x;
    longint              y;
    longint              xs;
    longint              ys;
    logic [31:0]         z;
    longint unsigned     rounded;
    int                  i;
    x = dx * (longint'(1) << GAIN_SHIFT);
    y = dy * (longint'(1) << GAIN_SHIFT);
    z = '0;
    if (x < 0) begin
      x = -x;
      y = -y;
      z = 32'h8000_0000;
    end
    for (i = 0; i < ROTATIONS; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y < 0) begin
        x = x - ys;
        y = y + xs;
        z = z - ARCTAN_HALF_TURNS[i];
      end else begin
        x = x + ys;
        y = y - xs;
        z = z + ARCTAN_HALF_TURNS[i];
      end
    end
    // round to nearest onto the output grid, ties up
    rounded = {32'b0, z} + (64'd1 << (30 - FRAC));
    rounded = rounded >> (31 - FRAC);
    return rounded[OUT_W-1:0];
  endfunction

  function automatic orientation_result_t orientation_difference(
      input logic border,
      input logic [PORT_W-1:0] fl, input logic [PORT_W-1:0] fr,
      input logic [PORT_W-1:0] fu, input logic [PORT_W-1:0] fd,
      input logic [PORT_W-1:0] sl, input logic [PORT_W-1:0] sr,
      input logic [PORT_W-1:0] su, input logic [PORT_W-1:0] sd);
    orientation_result_t r;
    longint              dx0;
    longint              dy0;
    longint              dx1;
    longint              dy1;
    logic [OUT_W-1:0]    d;
    if (border) begin
      r.defined = 1'b0;
      r.angle   = '0;
      return r;
    end
    dx0 = central_difference(fl, fr);
    dy0 = central_difference(fu, fd);
    dx1 = central_difference(sl, sr);
    dy1 = central_difference(su, sd);
    r.defined = 1'b1;
    if ((dx0 == 0 && dy0 == 0) || (dx1 == 0 && dy1 == 0)) begin
      r.angle = FULL_SCALE;
    end else begin
      d = gradient_heading(dx0, dy0) - gradient_heading(dx1, dy1);
      // fold into zero..half-turn
      if (d > FULL_SCALE) d = -d;
      r.angle = d;
    end
    return r;
  endfunction

  always @(posedge clk) begin
    orientation_result_t want;
    int                  errs;
    errs = 0;
    if (rst) begin
      expected_differences.delete();
      failures    <= 0;
      outstanding <= 0;
    end else begin
      if (in_valid && !in_stall) begin
        expected_differences.push_back(orientation_difference(on_border,
          first_left, first_right, first_up, first_down,
          second_left, second_right, second_up, second_down));
      end
      if (out_valid && !out_stall) begin
        if (expected_differences.size() == 0) begin
          $error("result with nothing expected: defined=%0d angle_difference=%0d",
                 defined, angle_difference);
          errs++;
        end else begin
          want = expected_differences.pop_front();
          if (defined !== want.defined) begin
            $error("defined: expected %0d, got %0d", want.defined, defined);
            errs++;
          end
          if (angle_difference !== want.angle) begin
            $error("angle_difference: expected %0d, got %0d", want.angle, angle_difference);
            errs++;
          end
        end
      end
      failures    <= failures + errs;
      outstanding <= expected_differences.size();
    end
  end

endmodule

FILE: tb/gradient_angle_difference_top_test.sv
// stimulus and verdict for the gradient angle difference block
module gradient_angle_difference_top_test import gad_pkg::*;;

  // generous ceiling for the watchdog
  localparam int CYCLE_LIMIT   = 200000;
  localparam int RANDOM_ITEMS  = 900;
  localparam int HOLD_CYCLES   = 120;
  // pipeline is 22 deep, leave some slack after the last result
  localparam int DRAIN_CYCLES  = 40;

  logic              clk;
  logic              rst;
  logic              in_valid;
  logic              in_stall;
  logic              on_border;
  logic [PORT_W-1:0] first_left;
  logic [PORT_W-1:0] first_right;
  logic [PORT_W-1:0] first_up;
  logic [PORT_W-1:0] first_down;
  logic [PORT_W-1:0] second_left;
  logic [PORT_W-1:0] second_right;
  logic [PORT_W-1:0] second_up;
  logic [PORT_W-1:0] second_down;
  logic              out_valid;
  logic              out_stall;
  logic              defined;
  logic [OUT_W-1:0]  angle_difference;

  int   failures;
  int   outstanding;
  int   cycles;
  int   results_seen;
  int   hold_left;
  // no idling on either side while set
  logic quiet;

  gradient_angle_difference_top uut (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .on_border        (on_border),
    .first_left       (first_left),
    .first_right      (first_right),
    .first_up         (first_up),
    .first_down       (first_down),
    .second_left      (second_left),
    .second_right     (second_right),
    .second_up        (second_up),
    .second_down      (second_down),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .defined          (defined),
    .angle_difference (angle_difference)
  );

  gradient_angle_difference_monitor monitor (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .on_border        (on_border),
    .first_left       (first_left),
    .first_right      (first_right),
    .first_up         (first_up),
    .first_down       (first_down),
    .second_left      (second_left),
    .second_right     (second_right),
    .second_up        (second_up),
    .second_down      (second_down),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .defined          (defined),
    .angle_difference (angle_difference),
    .failures         (failures),
    .outstanding      (outstanding)
  );

  // 12 unit clock
  initial clk = 1'b0;
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // watchdog
  initial cycles = 0;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // receiver: random stalls, plus two long hold-offs that back the pipeline
  // up into in_stall while the sender keeps offering requests
  initial begin
    out_stall    = 1'b0;
    results_seen = 0;
    hold_left    = 0;
    forever begin
      @(posedge clk);
      if (out_valid && !out_stall) begin
        results_seen++;
        if (results_seen == 250 || results_seen == 650) hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= !quiet && ($urandom_range(99) < 16);
      end
    end
  end

  // one request: optional idle gap first, then hold it until accepted
  task automatic send_pixel(input logic border,
                            input logic [PORT_W-1:0] fl, input logic [PORT_W-1:0] fr,
                            input logic [PORT_W-1:0] fu, input logic [PORT_W-1:0] fd,
                            input logic [PORT_W-1:0] sl, input logic [PORT_W-1:0] sr,
                            input logic [PORT_W-1:0] su, input logic [PORT_W-1:0] sd);
    while (!quiet && $urandom_range(99) < 16) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    on_border    <= border;
    first_left   <= fl;
    first_right  <= fr;
    first_up     <= fu;
    first_down   <= fd;
    second_left  <= sl;
    second_right <= sr;
    second_up    <= su;
    second_down  <= sd;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  initial begin
    int                n;
    int                k;
    int                kind;
    logic              border;
    logic [PORT_W-1:0] base;
    logic [PORT_W-1:0] v [8];

    rst          = 1'b1;
    quiet        = 1'b0;
    in_valid     = 1'b0;
    on_border    = 1'b0;
    first_left   = '0;
    first_right  = '0;
    first_up     = '0;
    first_down   = '0;
    second_left  = '0;
    second_right = '0;
    second_up    = '0;
    second_down  = '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // directed: border pixels, flat gradients, extremes, opposite and wrapping angles
    send_pixel(1'b1, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
                     16'h0000, 16'h0000, 16'h0000, 16'h0000);
    send_pixel(1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                     16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_pixel(1'b1, 16'h0000, 16'hFFFF, 16'hFFFF, 16'h0000,
                     16'hFFFF, 16'h0000, 16'h0000, 16'hFFFF);
    // first image flat
    send_pixel(1'b0, 16'd5, 16'd5, 16'd9, 16'd9, 16'd0, 16'd100, 16'd0, 16'd0);
    // second image flat
    send_pixel(1'b0, 16'd0, 16'd100, 16'd0, 16'd0, 16'd7, 16'd7, 16'd7, 16'd7);
    // both flat
    send_pixel(1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                     16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    // identical full-scale gradients
    send_pixel(1'b0, 16'h0000, 16'hFFFF, 16'h0000, 16'h0000,
                     16'h0000, 16'hFFFF, 16'h0000, 16'h0000);
    // opposite gradients, full scale and unit size
    send_pixel(1'b0, 16'h0000, 16'hFFFF, 16'h0000, 16'h0000,
                     16'hFFFF, 16'h0000, 16'h0000, 16'h0000);
    send_pixel(1'b0, 16'd0, 16'd1, 16'd0, 16'd0, 16'd1, 16'd0, 16'd0, 16'd0);
    send_pixel(1'b0, 16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF,
                     16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000);
    // just above and just below the negative x axis, difference wraps
    send_pixel(1'b0, 16'hFFFF, 16'h0000, 16'h0000, 16'h0001,
                     16'hFFFF, 16'h0000, 16'h0001, 16'h0000);
    // vertical gradients, up against down
    send_pixel(1'b0, 16'h0000, 16'h0000, 16'h0000, 16'hFFFF,
                     16'h0000, 16'h0000, 16'hFFFF, 16'h0000);
    // quarter and eighth turns
    send_pixel(1'b0, 16'd0, 16'd0, 16'd0, 16'd1, 16'd0, 16'd1, 16'd0, 16'd0);
    send_pixel(1'b0, 16'd0, 16'd0, 16'd1, 16'd0, 16'd1, 16'd0, 16'd0, 16'd0);
    send_pixel(1'b0, 16'h0000, 16'hFFFF, 16'hFFFF, 16'h0000,
                     16'h0000, 16'h0001, 16'h0000, 16'h0000);
    send_pixel(1'b0, 16'h0001, 16'h0000, 16'h0000, 16'h0000,
                     16'h0000, 16'h0000, 16'hFFFF, 16'h0000);
    // alternating bit patterns
    send_pixel(1'b0, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000,
                     16'hAAAA, 16'h5555, 16'h5555, 16'hAAAA);
    send_pixel(1'b0, 16'h5555, 16'hAAAA, 16'hAAAA, 16'h5555,
                     16'h0000, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    // tiny gradients near the top and bottom of the range, then full-scale diagonals
    send_pixel(1'b0, 16'h1234, 16'h1235, 16'hFFFE, 16'hFFFF,
                     16'h0000, 16'h0000, 16'h0000, 16'h0001);
    send_pixel(1'b0, 16'd0, 16'd3, 16'd0, 16'd4, 16'd0, 16'd4, 16'd0, 16'd3);
    send_pixel(1'b0, 16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000,
                     16'h0000, 16'hFFFF, 16'hFFFF, 16'h0000);

    // random part; v[] order is first l/r/u/d then second l/r/u/d
    for (n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == 350) quiet <= 1'b1;
      if (n == 500) quiet <= 1'b0;
      if (n == 700) begin
        // let the pipeline run dry before going on
        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
      end
      for (k = 0; k < 8; k++) v[k] = PORT_W'($urandom_range(65535));
      border = 1'b0;
      kind   = $urandom_range(99);
      if (kind < 10) begin
        border = 1'b1;
      end else if (kind < 16) begin
        // one of the two images has no gradient
        if ($urandom_range(1) == 0) begin
          v[1] = v[0];
          v[3] = v[2];
        end else begin
          v[5] = v[4];
          v[7] = v[6];
        end
      end else if (kind < 24) begin
        // second gradient exactly opposite the first
        v[4] = v[1];
        v[5] = v[0];
        v[6] = v[3];
        v[7] = v[2];
      end else if (kind < 30) begin
        for (k = 0; k < 4; k++) v[k+4] = v[k];
      end else if (kind < 60) begin
        // small gradients around a random level, coarse angles
        for (k = 0; k < 8; k++) begin
          if (k == 0 || k == 4) base = PORT_W'($urandom_range(65535));
          v[k] = base + PORT_W'($urandom_range(8)) - PORT_W'(4);
        end
      end
      send_pixel(border, v[0], v[1], v[2], v[3], v[4], v[5], v[6], v[7]);
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (failures == 0 && outstanding == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
